// File: rtl/ovn2d_pkg.sv
// Shared types and constants for the octave value noise block.
package ovn2d_pkg;

   localparam int GRID_SIDE_DEF   = 128;
   localparam int MAX_OCTAVES_DEF = 12;

   localparam logic [2:0]  SIZE_LOG2_RST    = 3'd7;
   localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd12;
   localparam logic [16:0] OCTAVE_RATIO_RST = 17'd32768;
   localparam logic [16:0] WEIGHT_ONE       = 17'd65536;

   localparam logic [3:0] ADDR_SIZE_LOG2    = 4'h0;
   localparam logic [3:0] ADDR_OCTAVE_COUNT = 4'h4;
   localparam logic [3:0] ADDR_OCTAVE_RATIO = 4'h8;

   localparam logic ACTION_WRITE = 1'b0;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_STORE, DP_TOP0, DP_TOP1, DP_BOT0, DP_BOT1,
      DP_V0, DP_V1, DP_SAMPLE, DP_ACCUM, DP_SKIP, DP_DIV_INIT, DP_DIV_STEP
   } dp_op_type;

   typedef enum logic [1:0] {
      CORNER_NW, CORNER_NE, CORNER_SW, CORNER_SE
   } corner_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_STORE, ST_OCT, ST_TOP0, ST_TOP1, ST_BOT0, ST_BOT1,
      ST_V0, ST_V1, ST_SAMP, ST_ACC, ST_DIVI, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      dp_op_type  op;
      logic       rd_en;
      corner_type corner;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic oct_more;
      logic oct_used;
      logic div_last;
   } status_type;

endpackage

// File: rtl/octave_value_noise_2d_top.sv
// A seed write stores its seed; a query blends each used octave, steps over each skipped one,
// then runs an NW-bit divide (NW = 33 + clog2(MAX_OCTAVES+1), 37 at defaults).
// Throughput: one transaction at a time; the octave loop reuses one blend multiplier
// and the single-port seed memory, and the divider retires one quotient bit per cycle.
// Reset: synchronous, active high; clears control and restores csr defaults.
// Seed memory is not cleared; entries are undefined until written.
module octave_value_noise_2d_top #(
   parameter int GRID_SIDE   = ovn2d_pkg::GRID_SIDE_DEF,
   parameter int MAX_OCTAVES = ovn2d_pkg::MAX_OCTAVES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // point_x[6:0], point_y[13:7], seed_value[29:14], zero
   input  logic [0:0]  req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // noise_value[15:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [2:0]  size_log2_ff;
   logic [3:0]  octave_count_ff;
   logic [16:0] octave_ratio_ff;
   logic        csr_wr;

   ovn2d_pkg::cmd_type    cmd;
   ovn2d_pkg::status_type status;

   // csr bank: written on the access phase of an APB write transaction
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff    <= ovn2d_pkg::SIZE_LOG2_RST;
         octave_count_ff <= ovn2d_pkg::OCTAVE_COUNT_RST;
         octave_ratio_ff <= ovn2d_pkg::OCTAVE_RATIO_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr)
            ovn2d_pkg::ADDR_SIZE_LOG2:    size_log2_ff    <= csr_pwdata[2:0];
            ovn2d_pkg::ADDR_OCTAVE_COUNT: octave_count_ff <= csr_pwdata[3:0];
            ovn2d_pkg::ADDR_OCTAVE_RATIO: octave_ratio_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ovn2d_pkg::ADDR_SIZE_LOG2:    csr_prdata = {29'd0, size_log2_ff};
         ovn2d_pkg::ADDR_OCTAVE_COUNT: csr_prdata = {28'd0, octave_count_ff};
         ovn2d_pkg::ADDR_OCTAVE_RATIO: csr_prdata = {15'd0, octave_ratio_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   ovn2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ovn2d_dpath #(
      .GRID_SIDE   (GRID_SIDE),
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .point_x      (req_tdata[6:0]),
      .point_y      (req_tdata[13:7]),
      .seed_value   (req_tdata[29:14]),
      .size_log2    (size_log2_ff),
      .octave_count (octave_count_ff),
      .octave_ratio (octave_ratio_ff),
      .cmd          (cmd),
      .status       (status),
      .noise_value  (rsp_tdata)
   );

   // a seed write transaction never produces a result
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == ovn2d_pkg::ACTION_WRITE)
      |=> !$rose(rsp_tvalid))
      else $error("result raised after a seed write");

   // a query holds off new transactions while it runs
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] != ovn2d_pkg::ACTION_WRITE)
      |=> !req_tready)
      else $error("input accepted during a query");

   // results are only produced at the end of a query
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised while idle");

endmodule

// File: rtl/ovn2d_ctrl.sv
// Controller state machine sequencing seed writes, octave passes and the divide.
module ovn2d_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_action,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  ovn2d_pkg::status_type status,
   output ovn2d_pkg::cmd_type    cmd
);

   ovn2d_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ovn2d_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd.op       = ovn2d_pkg::DP_NOP;
      cmd.rd_en    = 1'b0;
      cmd.corner   = ovn2d_pkg::CORNER_NW;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ovn2d_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = ovn2d_pkg::DP_LOAD;
               state_in = (req_action == ovn2d_pkg::ACTION_WRITE) ?
                          ovn2d_pkg::ST_STORE : ovn2d_pkg::ST_OCT;
            end
         end
         ovn2d_pkg::ST_STORE: begin
            cmd.op   = ovn2d_pkg::DP_STORE;
            state_in = ovn2d_pkg::ST_IDLE;
         end
         ovn2d_pkg::ST_OCT: begin
            if (!status.oct_more) begin
               state_in = ovn2d_pkg::ST_DIVI;
            end else if (!status.oct_used) begin
               cmd.op = ovn2d_pkg::DP_SKIP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.corner = ovn2d_pkg::CORNER_NW;
               state_in   = ovn2d_pkg::ST_TOP0;
            end
         end
         ovn2d_pkg::ST_TOP0: begin
            cmd.op     = ovn2d_pkg::DP_TOP0;
            cmd.rd_en  = 1'b1;
            cmd.corner = ovn2d_pkg::CORNER_NE;
            state_in   = ovn2d_pkg::ST_TOP1;
         end
         ovn2d_pkg::ST_TOP1: begin
            cmd.op     = ovn2d_pkg::DP_TOP1;
            cmd.rd_en  = 1'b1;
            cmd.corner = ovn2d_pkg::CORNER_SW;
            state_in   = ovn2d_pkg::ST_BOT0;
         end
         ovn2d_pkg::ST_BOT0: begin
            cmd.op     = ovn2d_pkg::DP_BOT0;
            cmd.rd_en  = 1'b1;
            cmd.corner = ovn2d_pkg::CORNER_SE;
            state_in   = ovn2d_pkg::ST_BOT1;
         end
         ovn2d_pkg::ST_BOT1: begin
            cmd.op   = ovn2d_pkg::DP_BOT1;
            state_in = ovn2d_pkg::ST_V0;
         end
         ovn2d_pkg::ST_V0: begin
            cmd.op   = ovn2d_pkg::DP_V0;
            state_in = ovn2d_pkg::ST_V1;
         end
         ovn2d_pkg::ST_V1: begin
            cmd.op   = ovn2d_pkg::DP_V1;
            state_in = ovn2d_pkg::ST_SAMP;
         end
         ovn2d_pkg::ST_SAMP: begin
            cmd.op   = ovn2d_pkg::DP_SAMPLE;
            state_in = ovn2d_pkg::ST_ACC;
         end
         ovn2d_pkg::ST_ACC: begin
            cmd.op   = ovn2d_pkg::DP_ACCUM;
            state_in = ovn2d_pkg::ST_OCT;
         end
         ovn2d_pkg::ST_DIVI: begin
            cmd.op   = ovn2d_pkg::DP_DIV_INIT;
            state_in = ovn2d_pkg::ST_DIV;
         end
         ovn2d_pkg::ST_DIV: begin
            cmd.op = ovn2d_pkg::DP_DIV_STEP;
            if (status.div_last) state_in = ovn2d_pkg::ST_OUT;
         end
         ovn2d_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ovn2d_pkg::ST_IDLE;
            end
         end
         default: state_in = ovn2d_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/ovn2d_dpath.sv
// Datapath: seed memory, bilinear blend, weighted accumulation and restoring divider.
module ovn2d_dpath #(
   parameter int GRID_SIDE   = ovn2d_pkg::GRID_SIDE_DEF,
   parameter int MAX_OCTAVES = ovn2d_pkg::MAX_OCTAVES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [6:0]            point_x,
   input  logic [6:0]            point_y,
   input  logic [15:0]           seed_value,
   input  logic [2:0]            size_log2,
   input  logic [3:0]            octave_count,
   input  logic [16:0]           octave_ratio,
   input  ovn2d_pkg::cmd_type    cmd,
   output ovn2d_pkg::status_type status,
   output logic [15:0]           noise_value
);

   localparam int CW  = $clog2(GRID_SIDE);
   localparam int AW  = 2 * CW;
   localparam int LGW = $clog2(CW + 1);
   localparam int OCW = $clog2(MAX_OCTAVES + 1);
   localparam int TW  = 16 + CW;
   localparam int VW  = 16 + 2 * CW;
   localparam int PW  = TW + CW + 1;
   localparam int SW  = 32 + OCW;
   localparam int WW  = 17 + OCW;
   localparam int NW  = SW + 1;
   localparam int DCW = $clog2(NW + 1);

   logic [15:0]    mem [GRID_SIDE*GRID_SIDE];
   logic [15:0]    rdata_ff;
   logic [AW-1:0]  rd_addr;

   logic [CW-1:0]  x_ff, y_ff, mask_ff;
   logic [15:0]    seed_ff;
   logic [LGW-1:0] lg_ff;
   logic [OCW-1:0] count_ff, oct_ff, oct_in;
   logic [16:0]    ratio_ff, w_ff, w_in;
   logic [TW-1:0]  top_ff, top_in, bot_ff, bot_in;
   logic [VW-1:0]  v_ff, v_in;
   logic [15:0]    sample_ff, sample_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [WW-1:0]  wsum_ff, wsum_in;
   logic [NW-1:0]  quo_ff, quo_in;
   logic [WW-1:0]  rem_ff, rem_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [15:0]    out_ff;

   logic [CW+6:0]  px_ext, py_ext;
   logic [LGW-1:0] lg_c, p;
   logic [CW:0]    side_c, pitch, pxd, pyd;
   logic [CW-1:0]  mask_c, pm, x1, y1, x2, y2, dx, dy;
   logic [OCW-1:0] count_c;
   logic [16:0]    ratio_c;
   logic [TW-1:0]  mul_a;
   logic [CW:0]    mul_b;
   logic [PW-1:0]  prod;
   logic [LGW:0]   sh;
   logic [VW:0]    half, rnd;
   logic [32:0]    sw_prod;
   logic [33:0]    wr_prod;
   logic [WW:0]    shifted, trial;

   // configuration clamps applied when a transaction is taken
   always_comb begin
      if (size_log2 == 3'd0)          lg_c = LGW'(1);
      else if (int'(size_log2) > CW)  lg_c = LGW'(CW);
      else                            lg_c = LGW'(size_log2);
      side_c  = (CW + 1)'(1) << lg_c;
      mask_c  = CW'(side_c - (CW + 1)'(1));
      px_ext  = {{CW{1'b0}}, point_x};
      py_ext  = {{CW{1'b0}}, point_y};
      count_c = (int'(octave_count) > MAX_OCTAVES) ? OCW'(MAX_OCTAVES) : OCW'(octave_count);
      ratio_c = (octave_ratio > ovn2d_pkg::WEIGHT_ONE) ? ovn2d_pkg::WEIGHT_ONE : octave_ratio;
   end

   // cell geometry of the current octave
   always_comb begin
      p     = lg_ff - LGW'(oct_ff);
      pitch = (CW + 1)'(1) << p;
      pm    = CW'(pitch - (CW + 1)'(1));
      x1    = x_ff & ~pm;
      y1    = y_ff & ~pm;
      dx    = x_ff & pm;
      dy    = y_ff & pm;
      x2    = CW'({1'b0, x1} + pitch) & mask_ff;
      y2    = CW'({1'b0, y1} + pitch) & mask_ff;
      pxd   = pitch - {1'b0, dx};
      pyd   = pitch - {1'b0, dy};
      unique case (cmd.corner)
         ovn2d_pkg::CORNER_NW: rd_addr = {y1, x1};
         ovn2d_pkg::CORNER_NE: rd_addr = {y1, x2};
         ovn2d_pkg::CORNER_SW: rd_addr = {y2, x1};
         ovn2d_pkg::CORNER_SE: rd_addr = {y2, x2};
         default:              rd_addr = {y1, x1};
      endcase
   end

   // shared blend multiplier
   always_comb begin
      case (cmd.op)
         ovn2d_pkg::DP_TOP0, ovn2d_pkg::DP_BOT0: begin
            mul_a = TW'(rdata_ff);
            mul_b = pxd;
         end
         ovn2d_pkg::DP_TOP1, ovn2d_pkg::DP_BOT1: begin
            mul_a = TW'(rdata_ff);
            mul_b = {1'b0, dx};
         end
         ovn2d_pkg::DP_V0: begin
            mul_a = top_ff;
            mul_b = pyd;
         end
         ovn2d_pkg::DP_V1: begin
            mul_a = bot_ff;
            mul_b = {1'b0, dy};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      sh      = {p, 1'b0};
      half    = ((VW + 1)'(1) << sh) >> 1;
      rnd     = ({1'b0, v_ff} + half) >> sh;
      sw_prod = 33'(sample_ff) * 33'(w_ff);
      wr_prod = 34'(w_ff) * 34'(ratio_ff);
      shifted = {rem_ff, quo_ff[NW-1]};
      trial   = shifted - {1'b0, wsum_ff};
   end

   always_comb begin
      top_in    = top_ff;
      bot_in    = bot_ff;
      v_in      = v_ff;
      sample_in = sample_ff;
      sum_in    = sum_ff;
      wsum_in   = wsum_ff;
      w_in      = w_ff;
      oct_in    = oct_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      case (cmd.op)
         ovn2d_pkg::DP_LOAD: begin
            sum_in  = '0;
            wsum_in = '0;
            w_in    = ovn2d_pkg::WEIGHT_ONE;
            oct_in  = '0;
         end
         ovn2d_pkg::DP_TOP0:   top_in = TW'(prod);
         ovn2d_pkg::DP_TOP1:   top_in = top_ff + TW'(prod);
         ovn2d_pkg::DP_BOT0:   bot_in = TW'(prod);
         ovn2d_pkg::DP_BOT1:   bot_in = bot_ff + TW'(prod);
         ovn2d_pkg::DP_V0:     v_in = VW'(prod);
         ovn2d_pkg::DP_V1:     v_in = v_ff + VW'(prod);
         ovn2d_pkg::DP_SAMPLE: sample_in = rnd[15:0];
         ovn2d_pkg::DP_ACCUM: begin
            sum_in  = sum_ff + SW'(sw_prod);
            wsum_in = wsum_ff + WW'(w_ff);
            w_in    = 17'((wr_prod + 34'd32768) >> 16);
            oct_in  = oct_ff + OCW'(1);
         end
         ovn2d_pkg::DP_SKIP: oct_in = oct_ff + OCW'(1);
         ovn2d_pkg::DP_DIV_INIT: begin
            quo_in  = NW'(sum_ff) + NW'(wsum_ff >> 1);
            rem_in  = '0;
            dcnt_in = DCW'(NW);
         end
         ovn2d_pkg::DP_DIV_STEP: begin
            if (!trial[WW]) begin
               rem_in = trial[WW-1:0];
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = shifted[WW-1:0];
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ovn2d_pkg::DP_STORE) mem[{y_ff, x_ff}] <= seed_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         oct_ff  <= oct_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ovn2d_pkg::DP_LOAD) begin
         x_ff     <= px_ext[CW-1:0] & mask_c;
         y_ff     <= py_ext[CW-1:0] & mask_c;
         mask_ff  <= mask_c;
         seed_ff  <= seed_value;
         lg_ff    <= lg_c;
         count_ff <= count_c;
         ratio_ff <= ratio_c;
      end
      top_ff    <= top_in;
      bot_ff    <= bot_in;
      v_ff      <= v_in;
      sample_ff <= sample_in;
      sum_ff    <= sum_in;
      wsum_ff   <= wsum_in;
      w_ff      <= w_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      if (cmd.out_load) out_ff <= (wsum_ff == '0) ? 16'd0 : quo_ff[15:0];
   end

   assign status.oct_more = oct_ff < count_ff;
   assign status.oct_used = int'(oct_ff) <= int'(lg_ff);
   assign status.div_last = dcnt_ff == DCW'(1);
   assign noise_value     = out_ff;

endmodule

// File: tb/tb_octave_value_noise_2d_top.sv
// Self-checking testbench for the octave value noise block: seed writes, noise queries, csr setup.
module tb_octave_value_noise_2d_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ACTION_QUERY = ~ovn2d_pkg::ACTION_WRITE;
   localparam int   SIDE         = 128;
   localparam int   SETTLE       = 200;   // longer than a 12 octave query

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   octave_value_noise_2d_top DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow of the block: register copies and seed grid, with a written-flag per entry
   // so that a query never touches a seed that was not loaded.
   logic [2:0]  size_reg  = ovn2d_pkg::SIZE_LOG2_RST;
   logic [3:0]  count_reg = ovn2d_pkg::OCTAVE_COUNT_RST;
   logic [16:0] ratio_reg = ovn2d_pkg::OCTAVE_RATIO_RST;
   logic [15:0] seed_grid [SIDE*SIDE];
   bit          seed_loaded [SIDE*SIDE];

   logic [15:0] noise_due [$];       // expected noise values, oldest first
   int          fail_count   = 0;
   int          writes_sent  = 0;
   int          queries_sent = 0;
   int          noise_seen   = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   // Noise at a point under the current register copies. Returns 0 when any corner
   // that the blend would read has never been written.
   function automatic bit predict_noise(input logic [6:0] px, input logic [6:0] py,
                                        output logic [15:0] noise);
      int unsigned lg, mask, x, y, cnt, rat, p, pitch, x1, y1, x2, y2, dx, dy;
      int unsigned idx [4];
      longint unsigned sum, wsum, w, top, bot, v, smp;
      bit ok;
      ok = 1'b1; sum = 0; wsum = 0; w = 65536;
      lg = size_reg;
      if (lg < 1) lg = 1;
      if (lg > 7) lg = 7;
      mask = (1 << lg) - 1;
      x = px & mask;
      y = py & mask;
      cnt = (count_reg > 12) ? 12 : count_reg;
      rat = (ratio_reg > 65536) ? 65536 : ratio_reg;
      for (int o = 0; o < cnt; o++) begin
         if (o > lg) continue;   // pitch already zero: skipped, weight untouched
         p = lg - o;
         pitch = 1 << p;
         x1 = x & ~(pitch - 1);
         y1 = y & ~(pitch - 1);
         x2 = (x1 + pitch) & mask;
         y2 = (y1 + pitch) & mask;
         dx = x - x1;
         dy = y - y1;
         idx[0] = y1 * SIDE + x1; idx[1] = y1 * SIDE + x2;
         idx[2] = y2 * SIDE + x1; idx[3] = y2 * SIDE + x2;
         foreach (idx[i]) if (!seed_loaded[idx[i]]) ok = 1'b0;
         top = seed_grid[idx[0]] * longint'(pitch - dx) + seed_grid[idx[1]] * longint'(dx);
         bot = seed_grid[idx[2]] * longint'(pitch - dx) + seed_grid[idx[3]] * longint'(dx);
         v = top * longint'(pitch - dy) + bot * longint'(dy);
         smp = (v + ((64'd1 << (2 * p)) >> 1)) >> (2 * p);
         sum += smp * w;
         wsum += w;
         w = (w * rat + 32768) >> 16;
      end
      noise = (wsum == 0) ? 16'd0 : 16'((sum + (wsum >> 1)) / wsum);
      return ok;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One transaction on the request channel. valid stays high across back-to-back
   // items and is lowered only when a gap follows.
   task automatic send_item(input logic act, input logic [6:0] px, input logic [6:0] py,
                            input logic [15:0] seed);
      int gap;
      logic [15:0] noise;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, seed, py, px};
      do @(posedge clock); while (!req_tready);
      if (act == ovn2d_pkg::ACTION_WRITE) begin
         int unsigned lg, mask;
         lg = (size_reg < 1) ? 1 : size_reg;
         mask = (1 << lg) - 1;
         seed_grid[(py & mask) * SIDE + (px & mask)]   = seed;
         seed_loaded[(py & mask) * SIDE + (px & mask)] = 1'b1;
         writes_sent++;
      end else begin
         void'(predict_noise(px, py, noise));
         noise_due.push_back(noise);
         queries_sent++;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (noise_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);   // a trailing write may still be in flight
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (addr)
         ovn2d_pkg::ADDR_SIZE_LOG2:    size_reg  = data[2:0];
         ovn2d_pkg::ADDR_OCTAVE_COUNT: count_reg = data[3:0];
         ovn2d_pkg::ADDR_OCTAVE_RATIO: ratio_reg = data[16:0];
         default: ;
      endcase
   endtask

   task automatic csr_check(input logic [3:0] addr, input logic [31:0] want);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b0; csr_penable <= 1'b0; csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want)
         report_mismatch($sformatf("csr 0x%0h read 0x%0h, want 0x%0h", addr, csr_prdata, want));
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic [2:0] sz, input logic [3:0] cnt, input logic [16:0] rat);
      csr_write(ovn2d_pkg::ADDR_SIZE_LOG2, 32'(sz));
      csr_write(ovn2d_pkg::ADDR_OCTAVE_COUNT, 32'(cnt));
      csr_write(ovn2d_pkg::ADDR_OCTAVE_RATIO, 32'(rat));
   endtask

   // Random query whose blend reads only loaded seeds; falls back to a write.
   task automatic send_random_query();
      logic [6:0] px, py;
      logic [15:0] noise;
      for (int t = 0; t < 32; t++) begin
         px = $urandom_range(0, 1) ? 7'($urandom) : 7'($urandom_range(0, 15));
         py = $urandom_range(0, 1) ? 7'($urandom) : 7'($urandom_range(0, 15));
         if (predict_noise(px, py, noise)) begin
            send_item(ACTION_QUERY, px, py, 16'($urandom));
            return;
         end
      end
      send_item(ovn2d_pkg::ACTION_WRITE, 7'($urandom_range(0, 15)), 7'($urandom_range(0, 15)),
                16'($urandom));
   endtask

   // ---- test: reset values, size below range, wrap of points, octave and ratio extremes
   task automatic test_directed();
      csr_check(ovn2d_pkg::ADDR_SIZE_LOG2, 32'(ovn2d_pkg::SIZE_LOG2_RST));
      csr_check(ovn2d_pkg::ADDR_OCTAVE_COUNT, 32'(ovn2d_pkg::OCTAVE_COUNT_RST));
      csr_check(ovn2d_pkg::ADDR_OCTAVE_RATIO, 32'(ovn2d_pkg::OCTAVE_RATIO_RST));
      set_config(3'd0, 4'd12, ovn2d_pkg::OCTAVE_RATIO_RST);   // size 0 acts as a 2x2 grid
      csr_check(ovn2d_pkg::ADDR_SIZE_LOG2, 32'd0);
      // far coordinates wrap onto the 2x2 grid
      send_item(ovn2d_pkg::ACTION_WRITE, 7'd0,   7'd0,   16'h0000);
      send_item(ovn2d_pkg::ACTION_WRITE, 7'd127, 7'd0,   16'hFFFF);
      send_item(ovn2d_pkg::ACTION_WRITE, 7'd0,   7'd127, 16'hFFFF);
      send_item(ovn2d_pkg::ACTION_WRITE, 7'd127, 7'd127, 16'h1234);
      send_item(ACTION_QUERY, 7'd0,   7'd0,   16'hFFFF);
      send_item(ACTION_QUERY, 7'd1,   7'd1,   16'h0000);
      send_item(ACTION_QUERY, 7'd127, 7'd126, 16'h0000);
      send_item(ACTION_QUERY, 7'd64,  7'd65,  16'hFFFF);
      drain();
      set_config(3'd1, 4'd0, ovn2d_pkg::OCTAVE_RATIO_RST);    // no octave: noise is zero
      send_item(ACTION_QUERY, 7'd1, 7'd0, 16'h0);
      drain();
      set_config(3'd1, 4'd15, 17'd0);              // count saturates, ratio zero
      send_item(ACTION_QUERY, 7'd1, 7'd1, 16'h0);
      send_item(ACTION_QUERY, 7'd0, 7'd1, 16'h0);
      drain();
      set_config(3'd1, 4'd2, 17'h1FFFF);           // ratio above 1.0 saturates
      csr_check(ovn2d_pkg::ADDR_OCTAVE_RATIO, 32'h1FFFF);
      send_item(ACTION_QUERY, 7'd1, 7'd1, 16'h0);
      send_item(ACTION_QUERY, 7'd0, 7'd0, 16'h0);
      drain();
      set_config(3'd1, 4'd1, 17'd1);
      send_item(ACTION_QUERY, 7'd1, 7'd0, 16'h0);
      drain();
   endtask

   // ---- test: load a dense 16x16 patch and a pitch-8 lattice over the full grid
   task automatic test_grid_load();
      set_config(3'd7, 4'd12, ovn2d_pkg::OCTAVE_RATIO_RST);
      for (int r = 0; r < 16; r++)
         for (int c = 0; c < 16; c++) begin
            send_item(ovn2d_pkg::ACTION_WRITE, 7'(c), 7'(r), 16'($urandom));
            send_item(ovn2d_pkg::ACTION_WRITE, 7'(c * 8), 7'(r * 8),
                      ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
         end
      drain();
   endtask

   // ---- test: random traffic over a series of register settings, extremes included
   task automatic test_random_settings();
      logic [2:0]  sz [9]  = '{3'd7, 3'd1, 3'd4, 3'd2, 3'd7, 3'd3, 3'd5, 3'd6, 3'd7};
      logic [3:0]  cnt [9] = '{4'd12, 4'd15, 4'd1, 4'd0, 4'd4, 4'd7, 4'd12, 4'd9, 4'd3};
      logic [16:0] rat [9] = '{17'd32768, 17'd0, 17'd65536, 17'd1, 17'h1FFFF,
                               17'd45000, 17'd1, 17'd65535, 17'd20000};
      for (int ph = 0; ph < 9; ph++) begin
         set_config(sz[ph], cnt[ph], (ph >= 6) ? 17'($urandom_range(0, 131071)) : rat[ph]);
         for (int n = 0; n < 90; n++) begin
            if ($urandom_range(0, 4) == 0)
               send_item(ovn2d_pkg::ACTION_WRITE, 7'($urandom), 7'($urandom),
                         ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                                      : 16'($urandom));
            else
               send_random_query();
            // sender holds off now and then until every result is back
            if ($urandom_range(0, 49) == 0) drain();
         end
         drain();
      end
   endtask

   // Result side: random back-pressure and the comparison with the oldest expectation.
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (noise_due.size() == 0)
               report_mismatch($sformatf("unexpected noise transaction 0x%0h", rsp_tdata));
            else begin
               logic [15:0] want;
               want = noise_due.pop_front();
               noise_seen++;
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("noise_value 0x%0h, want 0x%0h", rsp_tdata, want));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2: stall_left = $urandom_range(1, 3);
               3:       stall_left = $urandom_range(20, 60);
               default: stall_left = 0;
            endcase
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_grid_load();
      test_random_settings();
      drain();
      $display("Run covered %0d seed writes and %0d noise queries (%0d results checked)",
               writes_sent, queries_sent, noise_seen);
      $display("across grid sizes 2..128, 0..15 octaves and ratios from zero past 1.0");
      if (fail_count == 0 && noise_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d results outstanding", noise_due.size());
      $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
rtl/ovn2d_pkg.sv
rtl/ovn2d_ctrl.sv
rtl/ovn2d_dpath.sv
rtl/octave_value_noise_2d_top.sv
tb/tb_octave_value_noise_2d_top.sv
